>>> rtl/ers_pkg.sv
// Shared types, constants and codes of the elevator request scheduler.
`default_nettype none

package ers_pkg;

   localparam int unsigned FLOOR_W             = 4;
   localparam int unsigned FLOOR_VALUES        = 16;
   localparam int unsigned FLOOR_COUNT_DEFAULT = 16;
   localparam int unsigned STATUS_W            = 3;
   localparam int unsigned DIR_W               = 2;
   localparam int unsigned COUNT_W             = 5;

   localparam logic [FLOOR_W-1:0] TOP_FLOOR_RESET = 4'd10;

   localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DUP     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_INVALID = 3'd2;
   localparam logic [STATUS_W-1:0] ST_MOVED   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_ARRIVED = 3'd4;
   localparam logic [STATUS_W-1:0] ST_IDLE    = 3'd5;

   localparam logic [DIR_W-1:0] DIR_IDLE = 2'd0;
   localparam logic [DIR_W-1:0] DIR_UP   = 2'd1;
   localparam logic [DIR_W-1:0] DIR_DOWN = 2'd2;

   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_STEP = 1'b1;

   typedef struct packed {
      logic               op;
      logic [FLOOR_W-1:0] floor;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [FLOOR_W-1:0]  current_floor;
      logic [DIR_W-1:0]    direction;
      logic [FLOOR_W-1:0]  served_floor;
      logic [COUNT_W-1:0]  pending_count;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic move;
      logic reject;
      logic advance;
      logic insert;
   } ers_cmd_type;

   typedef struct packed {
      logic is_move;
      logic reject;
      logic scan_stop;
   } ers_sts_type;

endpackage

`default_nettype wire

>>> rtl/elevator_request_scheduler_core.sv
// Top level of the elevator request scheduler: controller plus datapath.
//
// Usage:
//   Input: drive req_data and pulse start; the transaction is taken at a clock
//   edge with start high and busy low. op 0 queues a floor call, op 1 moves
//   the car one step toward its target.
//   Result: rsp_data is shown for exactly one cycle with rsp_valid high. The
//   receiver cannot stall; every transaction gives exactly one result.
//   Configuration: top_floor is written through csr_valid/csr_ready/csr_data,
//   only while busy and start are low.
// Sequencing:
//   A step or a rejected call is decided in S_CHECK, and its result is
//   registered from there. An accepted call goes from S_CHECK to S_SCAN,
//   where the serial scan of the request list walks one entry per cycle to
//   the insertion position k (at most FLOOR_COUNT - 1), then inserts the
//   floor and registers the result. A new transaction is accepted at the
//   edge that ends the cycle its predecessor's result is shown.
// Reset: synchronous, active high; empties the list, clears all call marks,
//   puts the car on floor 0, idle, and top_floor back to 10.
`default_nettype none

module elevator_request_scheduler_core #(
   parameter int unsigned FLOOR_COUNT = ers_pkg::FLOOR_COUNT_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire ers_pkg::req_type            req_data,
   output logic                             rsp_valid,
   output ers_pkg::rsp_type                 rsp_data,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [ers_pkg::FLOOR_W-1:0] csr_data
);
   import ers_pkg::*;

   ers_cmd_type cmd;
   ers_sts_type sts;
   logic        csr_we;

   assign csr_ready = !busy && !start;
   assign csr_we    = csr_valid && csr_ready;

   ers_controller u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   ers_datapath #(
      .FLOOR_COUNT (FLOOR_COUNT)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

>>> rtl/ers_controller.sv
// Sequencer of the scheduler: capture, check, insertion scan.
`default_nettype none

module ers_controller (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire ers_pkg::ers_sts_type sts,
   output ers_pkg::ers_cmd_type     cmd
);
   import ers_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CHECK,
      S_SCAN
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.is_move) begin
               cmd.move = 1'b1;
               state_in = S_IDLE;
            end else if (sts.reject) begin
               cmd.reject = 1'b1;
               state_in   = S_IDLE;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (sts.scan_stop) begin
               cmd.insert = 1'b1;
               state_in   = S_IDLE;
            end else begin
               cmd.advance = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
      busy_in = (state_in != S_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy = busy_ff;

endmodule

`default_nettype wire

>>> rtl/ers_datapath.sv
// Scheduler datapath: request list, call marks, car state and result register.
`default_nettype none

module ers_datapath #(
   parameter int unsigned FLOOR_COUNT = ers_pkg::FLOOR_COUNT_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire ers_pkg::ers_cmd_type         cmd,
   output ers_pkg::ers_sts_type              sts,
   input  wire ers_pkg::req_type             req_data,
   input  wire logic                         csr_we,
   input  wire logic [ers_pkg::FLOOR_W-1:0]  csr_data,
   output logic                              rsp_valid,
   output ers_pkg::rsp_type                  rsp_data
);
   import ers_pkg::*;

   localparam int unsigned IDX_W = $clog2(FLOOR_COUNT);
   localparam int unsigned LEN_W = $clog2(FLOOR_COUNT + 1);

   logic [FLOOR_W-1:0]      list_ff [FLOOR_COUNT];
   logic [FLOOR_W-1:0]      list_in [FLOOR_COUNT];
   logic [LEN_W-1:0]        len_ff, len_in;
   logic [LEN_W-1:0]        pos_ff, pos_in;
   logic [FLOOR_VALUES-1:0] called_ff, called_in;
   logic [FLOOR_W-1:0]      car_ff, car_in;
   logic [DIR_W-1:0]        dir_ff, dir_in;
   logic [FLOOR_W-1:0]      target_ff, target_in;
   logic                    active_ff, active_in;
   logic [FLOOR_W-1:0]      top_ff, top_in;
   logic                    op_ff, op_in;
   logic [FLOOR_W-1:0]      floor_ff, floor_in;
   rsp_type                 rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic                    bad_floor, dup, full;
   logic [STATUS_W-1:0]     reject_status;
   logic [FLOOR_W-1:0]      entry, d_new, d_entry;
   logic                    nearer, same_side, pass;

   logic [FLOOR_W-1:0]      head, tgt, car_m, served_m;
   logic [DIR_W-1:0]        dir_m;
   logic [LEN_W-1:0]        len_m;
   logic                    pop, idle_step, active_m;
   logic [STATUS_W-1:0]     status_m;

   function automatic logic [FLOOR_W-1:0] floor_dist(input logic [FLOOR_W-1:0] a,
                                                      input logic [FLOOR_W-1:0] b);
      return (a >= b) ? (a - b) : (b - a);
   endfunction

   // request checks
   always_comb begin
      bad_floor = (floor_ff > top_ff) || (32'(floor_ff) >= FLOOR_COUNT);
      dup       = called_ff[floor_ff];
      full      = (len_ff >= LEN_W'(FLOOR_COUNT));
      if (bad_floor) begin
         reject_status = ST_INVALID;
      end else if (dup) begin
         reject_status = ST_DUP;
      end else begin
         reject_status = ST_INVALID;
      end
   end

   // insertion scan compare
   always_comb begin
      entry     = list_ff[pos_ff[IDX_W-1:0]];
      d_new     = floor_dist(floor_ff, car_ff);
      d_entry   = floor_dist(entry, car_ff);
      nearer    = (d_entry < d_new);
      same_side = ((dir_ff == DIR_UP) && (entry >= car_ff)) ||
                  ((dir_ff == DIR_DOWN) && (entry <= car_ff));
      pass      = (dir_ff == DIR_IDLE) ? nearer : (same_side && nearer);
   end

   always_comb begin
      sts           = '0;
      sts.is_move   = (op_ff == OP_STEP);
      sts.reject    = bad_floor || dup || full;
      sts.scan_stop = (pos_ff >= len_ff) || !pass;
   end

   // movement step
   always_comb begin
      head      = list_ff[0];
      pop       = !active_ff && (len_ff != '0);
      idle_step = !active_ff && (len_ff == '0);
      tgt       = active_ff ? target_ff : head;
      len_m     = pop ? (len_ff - LEN_W'(1)) : len_ff;
      car_m     = car_ff;
      dir_m     = dir_ff;
      active_m  = 1'b1;
      served_m  = '0;
      status_m  = ST_MOVED;
      if (idle_step) begin
         dir_m    = DIR_IDLE;
         active_m = active_ff;
         tgt      = target_ff;
         status_m = ST_IDLE;
      end else begin
         if (car_ff < tgt) begin
            car_m = car_ff + FLOOR_W'(1);
            dir_m = DIR_UP;
         end else if (car_ff > tgt) begin
            car_m = car_ff - FLOOR_W'(1);
            dir_m = DIR_DOWN;
         end
         if (car_m == tgt) begin
            served_m = tgt;
            active_m = 1'b0;
            status_m = ST_ARRIVED;
            if (len_m == '0) begin
               dir_m = DIR_IDLE;
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < FLOOR_COUNT; i++) begin
         list_in[i] = list_ff[i];
      end
      len_in       = len_ff;
      pos_in       = pos_ff;
      called_in    = called_ff;
      car_in       = car_ff;
      dir_in       = dir_ff;
      target_in    = target_ff;
      active_in    = active_ff;
      top_in       = csr_we ? csr_data : top_ff;
      op_in        = op_ff;
      floor_in     = floor_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;

      if (cmd.capture) begin
         op_in    = req_data.op;
         floor_in = req_data.floor;
         pos_in   = '0;
      end

      if (cmd.advance) begin
         pos_in = pos_ff + LEN_W'(1);
      end

      if (cmd.reject) begin
         rsp_valid_in         = 1'b1;
         rsp_in.status        = reject_status;
         rsp_in.current_floor = car_ff;
         rsp_in.direction     = dir_ff;
         rsp_in.served_floor  = '0;
         rsp_in.pending_count = COUNT_W'(len_ff);
      end

      if (cmd.insert) begin
         for (int i = 1; i < FLOOR_COUNT; i++) begin
            if (LEN_W'(i) > pos_ff) begin
               list_in[i] = list_ff[i-1];
            end
         end
         list_in[pos_ff[IDX_W-1:0]] = floor_ff;
         len_in                     = len_ff + LEN_W'(1);
         called_in[floor_ff]        = 1'b1;
         rsp_valid_in               = 1'b1;
         rsp_in.status              = ST_ADDED;
         rsp_in.current_floor       = car_ff;
         rsp_in.direction           = dir_ff;
         rsp_in.served_floor        = '0;
         rsp_in.pending_count       = COUNT_W'(len_ff + LEN_W'(1));
      end

      if (cmd.move) begin
         if (pop) begin
            for (int i = 0; i < FLOOR_COUNT - 1; i++) begin
               list_in[i] = list_ff[i+1];
            end
            called_in[head] = 1'b0;
         end
         len_in               = len_m;
         car_in               = car_m;
         dir_in               = dir_m;
         target_in            = tgt;
         active_in            = active_m;
         rsp_valid_in         = 1'b1;
         rsp_in.status        = status_m;
         rsp_in.current_floor = car_m;
         rsp_in.direction     = dir_m;
         rsp_in.served_floor  = served_m;
         rsp_in.pending_count = COUNT_W'(len_m);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < FLOOR_COUNT; i++) begin
         list_ff[i] <= list_in[i];
      end
      pos_ff   <= pos_in;
      op_ff    <= op_in;
      floor_ff <= floor_in;
      rsp_ff   <= rsp_in;
      if (reset) begin
         len_ff       <= '0;
         called_ff    <= '0;
         car_ff       <= '0;
         dir_ff       <= DIR_IDLE;
         target_ff    <= '0;
         active_ff    <= 1'b0;
         top_ff       <= TOP_FLOOR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         called_ff    <= called_in;
         car_ff       <= car_in;
         dir_ff       <= dir_in;
         target_ff    <= target_in;
         active_ff    <= active_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

>>> tb/sv/ers_schedule_checker.sv
// Checker for the elevator request scheduler: predicts each result and compares it.
`timescale 1ns / 100ps

module ers_schedule_checker (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic                        busy,
   input  wire ers_pkg::req_type            req_data,
   input  wire logic                        rsp_valid,
   input  wire ers_pkg::rsp_type            rsp_data,
   input  wire logic                        csr_valid,
   input  wire logic                        csr_ready,
   input  wire logic [ers_pkg::FLOOR_W-1:0] csr_data,
   output int                               fail_count,
   output int                               accepted_items,
   output int                               results_seen,
   output int                               top_writes,
   output int                               outstanding,
   output int                               peak_pending
);
   import ers_pkg::*;

   logic [FLOOR_W-1:0] call_list [FLOOR_VALUES];
   logic               called    [FLOOR_VALUES];
   int unsigned        list_len;
   logic [FLOOR_W-1:0] car;
   logic [DIR_W-1:0]   dir;
   logic [FLOOR_W-1:0] target;
   logic               target_on;
   logic [FLOOR_W-1:0] top_floor;

   rsp_type expected_results [$];

   function automatic int unsigned floor_gap(input logic [FLOOR_W-1:0] a,
                                             input logic [FLOOR_W-1:0] b);
      return (a >= b) ? int'(a - b) : int'(b - a);
   endfunction

   task automatic clear_model();
      for (int i = 0; i < FLOOR_VALUES; i++) begin
         call_list[i] = '0;
         called[i]    = 1'b0;
      end
      list_len  = 0;
      car       = '0;
      dir       = DIR_IDLE;
      target    = '0;
      target_on = 1'b0;
      top_floor = TOP_FLOOR_RESET;
   endtask

   task automatic schedule_item(input req_type r, output rsp_type e);
      int unsigned         pos;
      int unsigned         dnew;
      logic                nearer;
      logic                same;
      logic                pass;
      logic                stop;
      logic [STATUS_W-1:0] st;
      logic [FLOOR_W-1:0]  served;
      served = '0;
      if (r.op == OP_ADD) begin
         if (r.floor > top_floor) begin
            st = ST_INVALID;
         end else if (called[r.floor]) begin
            st = ST_DUP;
         end else if (list_len >= FLOOR_VALUES) begin
            st = ST_INVALID;
         end else begin
            // walk past entries that are nearer and, unless the car is idle, on the travel side
            dnew = floor_gap(r.floor, car);
            pos  = 0;
            stop = 1'b0;
            while (!stop && pos < list_len) begin
               nearer = floor_gap(call_list[pos], car) < dnew;
               same   = (dir == DIR_UP && call_list[pos] >= car) ||
                        (dir == DIR_DOWN && call_list[pos] <= car);
               pass   = (dir == DIR_IDLE) ? nearer : (same && nearer);
               if (pass) pos++;
               else stop = 1'b1;
            end
            for (int unsigned i = list_len; i > pos; i--) call_list[i] = call_list[i-1];
            call_list[pos]  = r.floor;
            list_len++;
            called[r.floor] = 1'b1;
            st = ST_ADDED;
         end
      end else begin
         st = ST_MOVED;
         if (!target_on && list_len == 0) begin
            dir = DIR_IDLE;
            st  = ST_IDLE;
         end else begin
            if (!target_on) begin
               target = call_list[0];
               for (int unsigned i = 0; i + 1 < list_len; i++) call_list[i] = call_list[i+1];
               list_len--;
               called[target] = 1'b0;
               target_on = 1'b1;
            end
            if (car < target) begin
               car = car + 1'b1;
               dir = DIR_UP;
            end else if (car > target) begin
               car = car - 1'b1;
               dir = DIR_DOWN;
            end
            if (car == target) begin
               served    = target;
               target_on = 1'b0;
               if (list_len == 0) dir = DIR_IDLE;
               st = ST_ARRIVED;
            end
         end
      end
      e.status        = st;
      e.current_floor = car;
      e.direction     = dir;
      e.served_floor  = served;
      e.pending_count = list_len[COUNT_W-1:0];
   endtask

   task automatic check_field(input string field, input int want, input int got);
      if (want != got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         clear_model();
         expected_results.delete();
         fail_count     = 0;
         accepted_items = 0;
         results_seen   = 0;
         top_writes     = 0;
         peak_pending   = 0;
      end else begin
         if (rsp_valid) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result, expected none, actual %h", $time, rsp_data);
            end else begin
               want = expected_results.pop_front();
               check_field("status", want.status, rsp_data.status);
               check_field("current_floor", want.current_floor, rsp_data.current_floor);
               check_field("direction", want.direction, rsp_data.direction);
               check_field("served_floor", want.served_floor, rsp_data.served_floor);
               check_field("pending_count", want.pending_count, rsp_data.pending_count);
            end
         end
         if (start && !busy) begin
            schedule_item(req_data, want);
            expected_results.push_back(want);
            accepted_items++;
            if (int'(want.pending_count) > peak_pending) peak_pending = want.pending_count;
         end
         if (csr_valid && csr_ready) begin
            top_floor = csr_data;
            top_writes++;
         end
      end
      outstanding = expected_results.size();
   end

endmodule

>>> tb/sv/tb.sv
// Testbench top for the elevator request scheduler: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb;
   import ers_pkg::*;

   localparam int STALL_LIMIT = 2000;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   req_type            req_data;
   logic               rsp_valid;
   rsp_type            rsp_data;
   logic               csr_valid;
   logic               csr_ready;
   logic [FLOOR_W-1:0] csr_data;

   int fail_count;
   int accepted_items;
   int results_seen;
   int top_writes;
   int outstanding;
   int peak_pending;

   int issued;
   int cur_top;

   elevator_request_scheduler_core u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   ers_schedule_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .fail_count     (fail_count),
      .accepted_items (accepted_items),
      .results_seen   (results_seen),
      .top_writes     (top_writes),
      .outstanding    (outstanding),
      .peak_pending   (peak_pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ends the run when no transaction moves for too long
   initial begin : watchdog
      int idle_cycles;
      int last_total;
      idle_cycles = 0;
      last_total  = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(negedge clock);
         if (accepted_items + results_seen + top_writes != last_total) begin
            last_total  = accepted_items + results_seen + top_writes;
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("tb: failure");
      $finish;
   end

   task automatic issue(input logic op, input logic [FLOOR_W-1:0] fl);
      int prev_count;
      int gap;
      gap = 0;
      if (!(issued >= 300 && issued < 480) && $urandom_range(99) < 30)
         gap = $urandom_range(6, 1);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      prev_count = accepted_items;
      start    <= 1'b1;
      req_data <= '{op: op, floor: fl};
      do @(negedge clock); while (accepted_items == prev_count);
      issued++;
   endtask

   task automatic write_top_floor(input logic [FLOOR_W-1:0] v);
      int prev_count;
      start <= 1'b0;
      do @(negedge clock); while (outstanding != 0 || busy);
      repeat (4) @(negedge clock);
      prev_count = top_writes;
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(negedge clock); while (top_writes == prev_count);
      csr_valid <= 1'b0;
      cur_top = v;
   endtask

   function automatic logic [FLOOR_W-1:0] pick_floor();
      if ($urandom_range(99) < 85) return FLOOR_W'($urandom_range(cur_top, 0));
      return FLOOR_W'($urandom_range(FLOOR_VALUES - 1, 0));
   endfunction

   initial begin : stimulus
      int n;
      int k;
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_data  = '0;
      issued    = 0;
      cur_top   = TOP_FLOOR_RESET;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // directed: idle step, target at car, bounds, duplicates, idle ordering
      issue(OP_STEP, 4'd15);
      issue(OP_ADD, 4'd0);
      issue(OP_STEP, 4'd0);
      issue(OP_ADD, 4'd10);
      issue(OP_ADD, 4'd11);
      issue(OP_ADD, 4'd15);
      issue(OP_ADD, 4'd10);
      issue(OP_ADD, 4'd4);
      issue(OP_ADD, 4'd2);
      issue(OP_ADD, 4'd7);
      issue(OP_STEP, 4'd0);
      issue(OP_ADD, 4'd2);
      issue(OP_ADD, 4'd1);
      write_top_floor(4'd15);
      issue(OP_ADD, 4'd15);
      issue(OP_ADD, 4'd14);
      write_top_floor(4'd0);
      issue(OP_ADD, 4'd1);
      issue(OP_ADD, 4'd0);
      repeat (8) issue(OP_STEP, FLOOR_W'($urandom_range(15, 0)));

      // random phases, each under its own top_floor
      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0, 3, 6: write_top_floor(4'd15);
            1:       write_top_floor(4'd9);
            2:       write_top_floor(4'd0);
            5:       write_top_floor(4'd3);
            default: write_top_floor(FLOOR_W'($urandom_range(15, 0)));
         endcase
         n = 0;
         while (n < 155) begin
            k = $urandom_range(99);
            if (k < 12) begin
               // burst of calls, then a drain run
               repeat ($urandom_range(20, 4)) begin
                  issue(OP_ADD, pick_floor());
                  n++;
               end
               repeat ($urandom_range(30, 3)) begin
                  issue(OP_STEP, FLOOR_W'($urandom_range(15, 0)));
                  n++;
               end
            end else if (k < 55) begin
               issue(OP_STEP, FLOOR_W'($urandom_range(15, 0)));
               n++;
            end else begin
               issue(OP_ADD, pick_floor());
               n++;
            end
         end
      end

      start <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (30) @(negedge clock);
      $display("run covered %0d transactions and %0d results over %0d top_floor writes",
               accepted_items, results_seen, top_writes);
      $display("deepest call list seen: %0d entries", peak_pending);
      if (fail_count == 0 && outstanding == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/ers_pkg.sv
rtl/ers_controller.sv
rtl/ers_datapath.sv
rtl/elevator_request_scheduler_core.sv
tb/sv/ers_schedule_checker.sv
tb/sv/tb.sv
